// ----- src/ffba_pkg.sv -----
package ffba_pkg;

  // Default configuration of the allocator.
  localparam int FFBA_MAX_BLOCKS   = 64;
  localparam int FFBA_HEADER_BYTES = 24;
  localparam int FFBA_ADDR_BITS    = 24;

  // Fixed field widths.
  localparam int DATA_W  = 24;
  localparam int LIMIT_W = 25;

  // Heap limit after reset: the whole 16 MiB region.
  localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RESET = 25'h100_0000;

  // Request kinds. Code 3 has no meaning and is answered with an empty result.
  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_RESIZE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOHEAP  = 3'd2,
    ST_FULL    = 3'd3,
    ST_DOUBLE  = 3'd4,
    ST_UNKNOWN = 3'd5
  } status_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_FIND,
    S_CHECK,
    S_FIT,
    S_GROW,
    S_FREE_OLD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] address_in;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] address_out;
    logic [DATA_W-1:0] copy_source;
    logic [DATA_W-1:0] copy_bytes;
  } rsp_t;

  typedef struct packed {
    cfg_index_t         index;
    logic [LIMIT_W-1:0] data;
  } cfg_t;

  // One row of the block table.
  typedef struct packed {
    logic              free;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] start;
  } entry_t;

endpackage

// ----- src/ffba_chan_if.sv -----
interface ffba_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- src/first_fit_block_allocator.sv -----
// First-fit heap block allocator without splitting. Requests arrive on req
// (allocate, release or resize) and each one produces exactly one response on
// rsp. heap_base and heap_limit are to be written through cfg only while the
// block is idle; the block itself does not enforce this. The block table
// lives in a synchronous memory with one write port and one registered read
// port and is searched one entry per cycle: allocate and release scan the
// table once, and a resize that has to move scans it twice. Requests that
// need no search (zero size, address 0, unused kind) skip the scan. A new
// request is taken while the previous response still waits in the output
// register. No clearing pass runs after reset; only entries below the block
// count are ever read.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = FFBA_MAX_BLOCKS,
  parameter int HEADER_BYTES = FFBA_HEADER_BYTES,
  parameter int ADDR_BITS    = FFBA_ADDR_BITS
) (
  input  logic clk,
  input  logic rst,
  ffba_chan_if.sink   req,
  ffba_chan_if.source rsp,
  ffba_chan_if.sink   cfg
);

  localparam int IW     = $clog2(MAX_BLOCKS);
  localparam int CW     = $clog2(MAX_BLOCKS + 1);
  localparam int NEED_W = 27;
  localparam int PAY_W  = 27;
  localparam int END_W  = (ADDR_BITS + 1 > 28) ? ADDR_BITS + 1 : 28;
  localparam logic [END_W-1:0] ADDR_LIMIT = END_W'(1) << ADDR_BITS;

  state_t state, state_next;

  // Configuration.
  logic [DATA_W-1:0]  heap_base;
  logic [LIMIT_W-1:0] heap_limit;

  // Allocator state beside the table.
  logic [CW-1:0]      count;
  logic [LIMIT_W-1:0] heap_top;

  // Request being served.
  logic [1:0]        kind_q;
  logic [DATA_W-1:0] size_q;
  logic [DATA_W-1:0] addr_q;
  logic              move_q;

  // Entry found by the address search.
  logic [IW-1:0]     found_idx;
  logic              found_free;
  logic [DATA_W-1:0] found_size;

  // Table scan.
  logic [CW-1:0] scan_idx;
  logic          rd_pend;
  logic [IW-1:0] rd_idx;
  entry_t        rd_data;
  logic          scan_issue;
  logic          scan_more;
  logic          scan_hit;
  logic          scan_miss;

  // Growth arithmetic, precomputed from stable values.
  logic [NEED_W-1:0] grow_need;
  logic [PAY_W-1:0]  grow_payload;
  logic [END_W-1:0]  grow_end;
  logic              no_heap;
  logic              table_full;

  // Result under construction and output register.
  status_t           res_status;
  logic [DATA_W-1:0] res_grant;
  logic [DATA_W-1:0] res_csrc;
  logic [DATA_W-1:0] res_cbytes;
  rsp_t              out_q;
  logic              out_valid;
  logic              out_free;

  // Table memory.
  entry_t        mem [MAX_BLOCKS];
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;

  logic req_fire;
  logic size_zero;

  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign size_zero = (size_q == '0);

  // Scan compare against the entry read in the previous cycle.
  assign scan_more = (scan_idx < count);
  always_comb begin
    if (state == S_FIND) begin
      scan_hit = rd_pend && (rd_data.start == addr_q);
    end else begin
      scan_hit = rd_pend && rd_data.free && (rd_data.size >= size_q);
    end
  end
  assign scan_miss = !rd_pend && !scan_more;

  // Growth checks.
  assign grow_end   = END_W'(grow_payload) + END_W'(size_q);
  assign no_heap    = (grow_need > NEED_W'(heap_limit)) || (grow_end > ADDR_LIMIT) ||
                      (grow_payload == '0);
  assign table_full = (count >= CW'(MAX_BLOCKS));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        case (kind_q)
          KIND_ALLOC: state_next = size_zero ? S_RESP : S_FIT;
          KIND_RELEASE: state_next = (addr_q == '0) ? S_RESP : S_FIND;
          KIND_RESIZE: begin
            if (addr_q != '0) begin
              state_next = S_FIND;
            end else begin
              state_next = size_zero ? S_RESP : S_FIT;
            end
          end
          default: state_next = S_RESP;
        endcase
      end
      S_FIND: begin
        if (scan_hit) begin
          state_next = S_CHECK;
        end else if (scan_miss) begin
          state_next = S_RESP;
        end
      end
      S_CHECK: begin
        if (found_free || kind_q == KIND_RELEASE || size_q <= found_size) begin
          state_next = S_RESP;
        end else begin
          state_next = S_FIT;
        end
      end
      S_FIT: begin
        if (scan_hit) begin
          state_next = move_q ? S_FREE_OLD : S_RESP;
        end else if (scan_miss) begin
          state_next = S_GROW;
        end
      end
      S_GROW: begin
        if (no_heap || table_full || !move_q) begin
          state_next = S_RESP;
        end else begin
          state_next = S_FREE_OLD;
        end
      end
      S_FREE_OLD: state_next = S_RESP;
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshakes, table writes and scan reads.
  always_comb begin
    req.ready   = (state == S_IDLE);
    cfg.ready   = 1'b1;
    rsp.valid   = out_valid;
    rsp.payload = out_q;
    mem_we      = 1'b0;
    mem_waddr   = found_idx;
    mem_wdata   = '{free: 1'b1, size: found_size, start: addr_q};
    scan_issue  = 1'b0;
    unique case (state)
      S_FIND: scan_issue = !scan_hit && scan_more;
      S_CHECK: begin
        mem_we = !found_free && (kind_q == KIND_RELEASE);
      end
      S_FIT: begin
        scan_issue = !scan_hit && scan_more;
        mem_we     = scan_hit;
        mem_waddr  = rd_idx;
        mem_wdata  = '{free: 1'b0, size: rd_data.size, start: rd_data.start};
      end
      S_GROW: begin
        mem_we    = !no_heap && !table_full;
        mem_waddr = count[IW-1:0];
        mem_wdata = '{free: 1'b0, size: size_q, start: grow_payload[DATA_W-1:0]};
      end
      S_FREE_OLD: mem_we = 1'b1;
      default: ;
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (scan_issue) begin
      rd_data <= mem[scan_idx[IW-1:0]];
    end
  end

  // Growth sums are refreshed every cycle from the request, heap base and top.
  always_ff @(posedge clk) begin
    grow_need    <= NEED_W'(heap_top) + NEED_W'(HEADER_BYTES) + NEED_W'(size_q);
    grow_payload <= PAY_W'(heap_base) + PAY_W'(heap_top) + PAY_W'(HEADER_BYTES);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      heap_top   <= '0;
      heap_base  <= '0;
      heap_limit <= HEAP_LIMIT_RESET;
      out_valid  <= 1'b0;
      scan_idx   <= '0;
      rd_pend    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid && cfg.ready) begin
        case (cfg.payload.index)
          CFG_HEAP_BASE:  heap_base <= cfg.payload.data[DATA_W-1:0];
          CFG_HEAP_LIMIT: heap_limit <= cfg.payload.data;
          default: ;
        endcase
      end

      // Scan pointer runs only inside the two search states.
      if (state == S_FIND || state == S_FIT) begin
        if (scan_issue) begin
          scan_idx <= scan_idx + CW'(1);
        end
        rd_pend <= scan_issue;
      end else begin
        scan_idx <= '0;
        rd_pend  <= 1'b0;
      end

      if (state == S_GROW && !no_heap && !table_full) begin
        count    <= count + CW'(1);
        heap_top <= grow_need[LIMIT_W-1:0];
      end

      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result datapath.
  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rd_idx <= scan_idx[IW-1:0];
    end
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          kind_q <= req.payload.kind;
          size_q <= req.payload.request_size;
          addr_q <= req.payload.address_in;
          move_q <= 1'b0;
        end
      end
      S_DECIDE: begin
        res_status <= ST_OK;
        res_grant  <= '0;
        res_csrc   <= '0;
        res_cbytes <= '0;
        if ((kind_q == KIND_ALLOC || (kind_q == KIND_RESIZE && addr_q == '0)) && size_zero) begin
          res_status <= ST_ZERO;
        end
      end
      S_FIND: begin
        if (scan_hit) begin
          found_idx  <= rd_idx;
          found_free <= rd_data.free;
          found_size <= rd_data.size;
        end else if (scan_miss) begin
          res_status <= ST_UNKNOWN;
        end
      end
      S_CHECK: begin
        if (found_free) begin
          res_status <= ST_DOUBLE;
        end else if (kind_q == KIND_RESIZE) begin
          if (size_q <= found_size) begin
            res_grant <= addr_q;
          end else begin
            move_q <= 1'b1;
          end
        end
      end
      S_FIT: begin
        if (scan_hit) begin
          res_grant <= rd_data.start;
        end
      end
      S_GROW: begin
        if (no_heap) begin
          res_status <= ST_NOHEAP;
        end else if (table_full) begin
          res_status <= ST_FULL;
        end else begin
          res_grant <= grow_payload[DATA_W-1:0];
        end
      end
      S_FREE_OLD: begin
        res_csrc   <= addr_q;
        res_cbytes <= found_size;
      end
      S_RESP: begin
        if (out_free) begin
          out_q <= '{status: res_status, address_out: res_grant,
                     copy_source: res_csrc, copy_bytes: res_cbytes};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // The table never holds more entries than it has rows.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BLOCKS))
    else $error("block count exceeds table depth");

  // Writes touch only live entries or append right after them.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CW'(mem_waddr) <= count))
    else $error("table write beyond block count");

  // A read result is pending only while a search is running.
  a_scan_local: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_FIND || state == S_FIT))
    else $error("stale table read outside a search");

  // A failed request grants no address.
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_q.status == ST_OK || out_q.address_out == '0))
    else $error("failed request returned an address");

  // A copy is reported only for a successful moving resize.
  a_copy_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.copy_bytes != '0) |->
      (out_q.status == ST_OK && out_q.copy_source != '0 && out_q.address_out != '0))
    else $error("copy reported without a granted block");
`endif

endmodule

// ----- test/allocator_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, response and configuration channels of the allocator.
// It keeps its own copy of the block table and predicts every response.
module allocator_checker import ffba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_payload,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp_payload,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  cfg_t cfg_payload,
  output int   pending,
  output int   failures
);

  // Shadow copy of the block table and the heap registers.
  logic [DATA_W-1:0]  blk_start [FFBA_MAX_BLOCKS];
  logic [DATA_W-1:0]  blk_size  [FFBA_MAX_BLOCKS];
  logic               blk_free  [FFBA_MAX_BLOCKS];
  int                 blk_count;
  logic [LIMIT_W-1:0] heap_used;
  logic [DATA_W-1:0]  heap_base_reg;
  logic [LIMIT_W-1:0] heap_limit_reg;

  // Responses still owed by the allocator, oldest first.
  rsp_t awaited_answers[$];

  // Takes the first free block that is large enough, or grows the heap.
  function automatic status_t grant_first_fit(input logic [DATA_W-1:0] size,
                                              output logic [DATA_W-1:0] addr);
    logic [63:0] need;
    logic [63:0] payload;
    logic [63:0] pay_end;
    addr = '0;
    if (size == '0) return ST_ZERO;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= size) begin
        blk_free[i] = 1'b0;
        addr = blk_start[i];
        return ST_OK;
      end
    end
    need    = 64'(heap_used) + 64'(FFBA_HEADER_BYTES) + 64'(size);
    payload = 64'(heap_base_reg) + 64'(heap_used) + 64'(FFBA_HEADER_BYTES);
    pay_end = payload + 64'(size);
    if (need > 64'(heap_limit_reg) || pay_end > (64'd1 << FFBA_ADDR_BITS) || payload == 0)
      return ST_NOHEAP;
    if (blk_count >= FFBA_MAX_BLOCKS) return ST_FULL;
    blk_start[blk_count] = payload[DATA_W-1:0];
    blk_size[blk_count]  = size;
    blk_free[blk_count]  = 1'b0;
    blk_count++;
    heap_used = need[LIMIT_W-1:0];
    addr = payload[DATA_W-1:0];
    return ST_OK;
  endfunction

  // First table entry holding this payload address, or -1.
  function automatic int find_block(input logic [DATA_W-1:0] addr);
    for (int i = 0; i < blk_count; i++) begin
      if (blk_start[i] == addr) return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the response it owes.
  function automatic rsp_t answer_request(input req_t r);
    rsp_t        o;
    logic [DATA_W-1:0] grant;
    int          idx;
    o = '0;
    grant = '0;
    case (r.kind)
      KIND_ALLOC: begin
        o.status = grant_first_fit(r.request_size, grant);
        o.address_out = grant;
      end
      KIND_RELEASE: begin
        if (r.address_in != '0) begin
          idx = find_block(r.address_in);
          if (idx < 0) o.status = ST_UNKNOWN;
          else if (blk_free[idx]) o.status = ST_DOUBLE;
          else blk_free[idx] = 1'b1;
        end
      end
      KIND_RESIZE: begin
        if (r.address_in == '0) begin
          o.status = grant_first_fit(r.request_size, grant);
          o.address_out = grant;
        end else begin
          idx = find_block(r.address_in);
          if (idx < 0) begin
            o.status = ST_UNKNOWN;
          end else if (blk_free[idx]) begin
            o.status = ST_DOUBLE;
          end else if (blk_size[idx] >= r.request_size) begin
            o.address_out = r.address_in;
          end else begin
            // The block must move: the old one is freed only if the new one exists.
            o.status = grant_first_fit(r.request_size, grant);
            o.address_out = grant;
            if (o.status == ST_OK) begin
              blk_free[idx] = 1'b1;
              o.copy_source = r.address_in;
              o.copy_bytes  = blk_size[idx];
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      if (failures < 10)
        $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                 $realtime, field, want, want, got, got);
      failures++;
    end
  endtask

  // Responses are checked before a request of the same edge is predicted.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      heap_base_reg  = '0;
      heap_limit_reg = HEAP_LIMIT_RESET;
      blk_count      = 0;
      heap_used      = '0;
      failures       = 0;
      awaited_answers.delete();
      pending <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_answers.size() == 0) begin
          if (failures < 10)
            $display("%0t: response with no request outstanding, status %0d address 0x%0h",
                     $realtime, rsp_payload.status, rsp_payload.address_out);
          failures++;
        end else begin
          want = awaited_answers.pop_front();
          check_field("status", int'(want.status), int'(rsp_payload.status));
          check_field("address_out", int'(want.address_out), int'(rsp_payload.address_out));
          check_field("copy_source", int'(want.copy_source), int'(rsp_payload.copy_source));
          check_field("copy_bytes", int'(want.copy_bytes), int'(rsp_payload.copy_bytes));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_payload.index)
          CFG_HEAP_BASE:  heap_base_reg  = cfg_payload.data[DATA_W-1:0];
          CFG_HEAP_LIMIT: heap_limit_reg = cfg_payload.data;
          default: ;
        endcase
      end
      if (req_valid && req_ready) awaited_answers.push_back(answer_request(req_payload));
      pending <= awaited_answers.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ffba_pkg::*;

  localparam int         CYCLE_LIMIT  = 1_000_000;
  localparam int         DRAIN_CYCLES = 150;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         POOL_DEPTH   = 96;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int          cycles = 0;
  int          pending;
  int          failures;

  // Payload addresses handed out so far, used to aim releases and resizes.
  logic [DATA_W-1:0] granted[$];
  logic [DATA_W-1:0] last_grant = '0;

  ffba_chan_if #(.T(req_t)) req_if ();
  ffba_chan_if #(.T(rsp_t)) rsp_if ();
  ffba_chan_if #(.T(cfg_t)) cfg_if ();

  first_fit_block_allocator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  allocator_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_if.valid),
    .req_ready   (req_if.ready),
    .req_payload (req_if.payload),
    .rsp_valid   (rsp_if.valid),
    .rsp_ready   (rsp_if.ready),
    .rsp_payload (rsp_if.payload),
    .cfg_valid   (cfg_if.valid),
    .cfg_ready   (cfg_if.ready),
    .cfg_payload (cfg_if.payload),
    .pending     (pending),
    .failures    (failures)
  );

  always #5 clk = ~clk;

  // Response side stalls at random.
  always @(posedge clk) begin
    if (rst) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Remember granted addresses so later requests can hit real blocks.
  always @(posedge clk) begin
    if (rsp_if.valid && rsp_if.ready && rsp_if.payload.status == ST_OK &&
        rsp_if.payload.address_out != '0) begin
      last_grant <= rsp_if.payload.address_out;
      granted.push_back(rsp_if.payload.address_out);
      if (granted.size() > POOL_DEPTH) void'(granted.pop_front());
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[first_fit_block_allocator] ERROR");
      $finish;
    end
  end

  // Offers one request, with an optional random gap, and waits until it is taken.
  task automatic send_request(input req_t r);
    if ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Holds off new requests until every response has come back.
  task automatic wait_for_answers();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic request_and_settle(input logic [1:0] kind, input logic [DATA_W-1:0] size,
                                    input logic [DATA_W-1:0] addr);
    req_t r;
    r.kind = kind;
    r.request_size = size;
    r.address_in = addr;
    send_request(r);
    wait_for_answers();
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [LIMIT_W-1:0] value);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{index: idx, data: value};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small blocks aimed at known addresses, with some noise mixed in.
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) r.request_size = DATA_W'($urandom_range(64, 1));
    else if (pick < 85) r.request_size = DATA_W'($urandom_range(4096, 65));
    else if (pick < 90) r.request_size = '0;
    else if (pick < 95) r.request_size = DATA_W'($urandom());
    else r.request_size = '1;
    pick = $urandom_range(99);
    if (pick < 70 && granted.size() != 0)
      r.address_in = granted[$urandom_range(granted.size() - 1)];
    else if (pick < 80) r.address_in = '0;
    else if (pick < 90 && granted.size() != 0)
      r.address_in = granted[$urandom_range(granted.size() - 1)] + DATA_W'($urandom_range(3, 1));
    else if (pick < 97) r.address_in = DATA_W'($urandom());
    else r.address_in = '1;
    pick = $urandom_range(99);
    if (pick < 40) r.kind = KIND_ALLOC;
    else if (pick < 65) r.kind = KIND_RELEASE;
    else if (pick < 95) r.kind = KIND_RESIZE;
    else r.kind = KIND_UNUSED;
    return r;
  endfunction

  // One phase: new heap settings, new idling mix, then random requests.
  task automatic run_random(input logic [DATA_W-1:0] base, input logic [LIMIT_W-1:0] limit,
                            input int unsigned gap, input int unsigned stall, input int count);
    req_t r;
    int   done;
    write_register(CFG_HEAP_BASE, LIMIT_W'(base));
    write_register(CFG_HEAP_LIMIT, limit);
    gap_pct   = gap;
    stall_pct = stall;
    done = 0;
    while (done < count) begin
      r = random_request();
      send_request(r);
      if (r.kind != KIND_UNUSED) done++;
      if ($urandom_range(49) == 0) wait_for_answers();
    end
    wait_for_answers();
  endtask

  initial begin
    logic [DATA_W-1:0] blk_a;
    logic [DATA_W-1:0] blk_b;
    logic [DATA_W-1:0] blk_c;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    gap_pct   = 6;
    stall_pct = 62;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset configuration.
    request_and_settle(KIND_ALLOC, '0, '0);
    request_and_settle(KIND_ALLOC, 24'd1, '0);
    blk_a = last_grant;
    request_and_settle(KIND_ALLOC, '1, '0);
    request_and_settle(KIND_ALLOC, 24'd40, '0);
    blk_b = last_grant;
    request_and_settle(KIND_RELEASE, '0, '0);
    request_and_settle(KIND_RELEASE, '0, '1);
    request_and_settle(KIND_RELEASE, '0, blk_a);
    // Releasing or resizing a block that is already free.
    request_and_settle(KIND_RELEASE, '0, blk_a);
    request_and_settle(KIND_RESIZE, 24'd8, blk_a);
    request_and_settle(KIND_ALLOC, 24'd1, '0);
    // Resizes that fit in place, including a zero size.
    request_and_settle(KIND_RESIZE, '0, blk_a);
    request_and_settle(KIND_RESIZE, 24'd1, blk_a);
    // A resize that has to move and copy.
    request_and_settle(KIND_RESIZE, 24'd100, blk_a);
    blk_c = last_grant;
    request_and_settle(KIND_RESIZE, 24'd16, '0);
    request_and_settle(KIND_RESIZE, '0, '0);
    request_and_settle(KIND_RESIZE, 24'd5, 24'h800001);
    // A moving resize that cannot get space keeps the old block.
    request_and_settle(KIND_RESIZE, '1, blk_b);
    request_and_settle(KIND_UNUSED, '1, '1);
    // First fit must skip a free block that is too small.
    request_and_settle(KIND_RELEASE, '0, blk_b);
    request_and_settle(KIND_RELEASE, '0, blk_c);
    request_and_settle(KIND_ALLOC, 24'd50, '0);
    request_and_settle(KIND_ALLOC, 24'd40, '0);

    // Random phases over several heap settings and idling mixes.
    run_random(24'h000400, 25'h100_0000, 6, 62, 120);
    run_random(24'h000000, 25'h000_0000, 6, 62, 100);
    run_random(24'hFFFFFF, 25'h100_0000, 62, 6, 110);
    run_random(24'h7FF000, 25'h00F_FFFF, 62, 6, 110);
    run_random(24'h000000, 25'h100_0000, 0, 0, 120);
    run_random(24'h3A5C00, 25'h040_0000, 0, 0, 120);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[first_fit_block_allocator] OK");
    end else begin
      $display("[first_fit_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
